// ----- hw/rtl/lvd_pkg.sv -----
package lvd_pkg;

  localparam int MAX_LEN    = 32;
  localparam int IDX_W      = $clog2(MAX_LEN + 1);
  localparam int CHAR_IDX_W = $clog2(MAX_LEN);
  localparam int DIST_W     = 6;
  localparam int SYM_W      = 8;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_FIRST  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              error;
  } result_t;

  // Operands of one dynamic-programming cell.
  typedef struct packed {
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
    logic              mismatch;
  } cell_in_t;

endpackage

// ----- hw/rtl/lvd_cell_unit.sv -----
module lvd_cell_unit (
  input  lvd_pkg::cell_in_t          operands,
  output logic [lvd_pkg::DIST_W-1:0] cell_cost
);
  import lvd_pkg::*;

  logic [DIST_W-1:0] ins_cost;
  logic [DIST_W-1:0] del_cost;
  logic [DIST_W-1:0] sub_cost;
  logic [DIST_W-1:0] min_ab;

  always_comb begin
    ins_cost  = operands.up + DIST_W'(1);
    del_cost  = operands.left + DIST_W'(1);
    sub_cost  = operands.diag + DIST_W'(operands.mismatch);
    min_ab    = (ins_cost < del_cost) ? ins_cost : del_cost;
    cell_cost = (min_ab < sub_cost) ? min_ab : sub_cost;
  end

endmodule

// ----- hw/rtl/levenshtein_distance_core.sv -----
// Load and ignored transactions leave busy low.
// A first-string character that is not dropped for overflow is processed one row
// cell per cycle through the shared cell unit and the single row memory read
// port, with no stall during the pass.
// A finish transaction passes through S_FIN and S_EMIT; its result is registered with done.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset clears the counts and flags; the memories are not cleared.
module levenshtein_distance_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  lvd_pkg::req_t    req,
  output logic             busy,
  output logic             done,
  output lvd_pkg::result_t result
);
  import lvd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_EMIT} state_t;

  state_t            state;
  logic [IDX_W-1:0]  second_count;
  logic [IDX_W-1:0]  first_count;
  logic              row_started;
  logic              error_seen;
  logic              init;
  logic [SYM_W-1:0]  ch;
  logic [IDX_W-1:0]  rd_idx;
  logic              issue_v;
  logic [IDX_W-1:0]  stage_idx;
  logic              stage_v;
  logic [DIST_W-1:0] left;
  logic [DIST_W-1:0] diag;

  logic [SYM_W-1:0]  chars_mem [MAX_LEN];
  logic [DIST_W-1:0] row_mem [MAX_LEN+1];
  logic [SYM_W-1:0]  char_q;
  logic [DIST_W-1:0] row_q;

  logic              accept;
  logic              chars_we;
  logic              row_we;
  logic [IDX_W-1:0]  char_addr;
  logic [DIST_W-1:0] up_val;
  logic [DIST_W-1:0] wr_val;
  logic [DIST_W-1:0] cell_cost;
  cell_in_t          operands;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    chars_we = accept && (req.req_type == REQ_LOAD) && !row_started &&
               (second_count < IDX_W'(MAX_LEN));
    row_we   = (state == S_RUN) && stage_v;
    char_addr = rd_idx - IDX_W'(1);
    // Before the first pass the row holds its index, so the read is bypassed.
    up_val   = init ? DIST_W'(stage_idx) : row_q;
    operands.up       = up_val;
    operands.left     = left;
    operands.diag     = diag;
    operands.mismatch = (char_q != ch);
    wr_val   = (stage_idx == '0) ? DIST_W'(first_count + IDX_W'(1)) : cell_cost;
  end

  lvd_cell_unit u_cell (
    .operands  (operands),
    .cell_cost (cell_cost)
  );

  always_ff @(posedge clk) begin
    if (chars_we) begin
      chars_mem[second_count[CHAR_IDX_W-1:0]] <= req.symbol;
    end
    char_q <= chars_mem[char_addr[CHAR_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[stage_idx] <= wr_val;
    end
    row_q <= row_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      second_count <= '0;
      first_count  <= '0;
      row_started  <= 1'b0;
      error_seen   <= 1'b0;
      issue_v      <= 1'b0;
      stage_v      <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_LOAD: begin
                if (row_started || second_count >= IDX_W'(MAX_LEN)) begin
                  error_seen <= 1'b1;
                end else begin
                  second_count <= second_count + IDX_W'(1);
                end
              end
              REQ_FIRST: begin
                row_started <= 1'b1;
                if (first_count >= IDX_W'(MAX_LEN)) begin
                  error_seen <= 1'b1;
                end else begin
                  init    <= !row_started;
                  ch      <= req.symbol;
                  rd_idx  <= '0;
                  issue_v <= 1'b1;
                  stage_v <= 1'b0;
                  state   <= S_RUN;
                end
              end
              REQ_FINISH: begin
                rd_idx <= second_count;
                state  <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          stage_v   <= issue_v;
          stage_idx <= rd_idx;
          if (issue_v) begin
            if (rd_idx == second_count) begin
              issue_v <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          if (stage_v) begin
            left <= wr_val;
            diag <= up_val;
            if (stage_idx == second_count) begin
              first_count <= first_count + IDX_W'(1);
              stage_v     <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          result.distance <= row_started ? row_q : DIST_W'(second_count);
          result.error    <= error_seen;
          done            <= 1'b1;
          second_count    <= '0;
          first_count     <= '0;
          row_started     <= 1'b0;
          error_seen      <= 1'b0;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
